// ----- hdl/rta_pkg.sv -----
// ----------------------------------------------------------------------------
// rta_pkg
// Shared types and constants for the response-time admission controller.
// ----------------------------------------------------------------------------
package rta_pkg;

  localparam int SLOTS     = 10;
  localparam int TIME_BITS = 24;

  // index over the slots plus one extra code for the new task
  localparam int IW = $clog2(SLOTS + 1);
  // index into the slot arrays
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic CMD_DEACTIVATE = 1'b0;
  localparam logic CMD_ACTIVATE   = 1'b1;

  typedef enum logic [1:0] {
    STAT_ADMIT   = 2'd0,
    STAT_NOSCHED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_DEACT   = 2'd3
  } status_t;

  typedef struct packed {
    logic                 command;
    logic [5:0]           task_id;
    logic [TIME_BITS-1:0] wcet;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] deadline;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] slot;
    logic [3:0] removed_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_NEXT_I,
    S_J_SCAN,
    S_DIV,
    S_MUL,
    S_ACC,
    S_PASS_END,
    S_ADMIT,
    S_REJECT,
    S_RESP
  } state_t;

endpackage

// ----- hdl/rta_div.sv -----
// ----------------------------------------------------------------------------
// rta_div
// Bit-serial restoring divider: one quotient bit per cycle, gives the
// quotient and whether a remainder is left (for the ceiling).
// ----------------------------------------------------------------------------
module rta_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rta_pkg::TIME_BITS-1:0] dividend,
  input  logic [rta_pkg::TIME_BITS-1:0] divisor,
  output logic                          done,
  output logic [rta_pkg::TIME_BITS-1:0] quotient,
  output logic                          rem_nz
);
  import rta_pkg::*;

  localparam int CW = $clog2(TIME_BITS);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] quo;
  logic [TIME_BITS-1:0] dvs;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS-1:0] rem_next;
  logic                 qbit;

  always_comb begin
    trial = {rem, quo[TIME_BITS-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = TIME_BITS'(trial - {1'b0, dvs});
      qbit     = 1'b1;
    end else begin
      rem_next = trial[TIME_BITS-1:0];
      qbit     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[TIME_BITS-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(TIME_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign rem_nz   = (rem != '0);

endmodule

// ----- hdl/rta_admission_control.sv -----
// ----------------------------------------------------------------------------
// rta_admission_control
// Deadline-monotonic admission control: keeps a table of periodic tasks and
// admits a new one only if response-time analysis shows all deadlines met.
// ----------------------------------------------------------------------------
// Flow: deactivate and table-full answers go from the decode state straight
//   to the response state. An activation runs a fixed-point iteration per task;
//   each interfering term goes through the shared serial divider, then the
//   multiply and accumulate states.
// Throughput: one request at a time; req_ready is high only when idle and
//   out of reset.
// Reset: rst (sync) empties the table and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module rta_admission_control (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rta_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rta_pkg::rsp_t rsp
);
  import rta_pkg::*;

  localparam int TB = TIME_BITS;

  // task table
  logic [SLOTS-1:0] slot_valid;
  logic [5:0]       slot_task     [SLOTS];
  logic [TB-1:0]    slot_exec     [SLOTS];
  logic [TB-1:0]    slot_period   [SLOTS];
  logic [TB-1:0]    slot_deadline [SLOTS];

  state_t state, state_next;

  req_t          req_q;
  logic [IW-1:0] i;        // task under analysis (SLOTS = new task)
  logic [IW-1:0] j;        // interfering candidate
  logic [TB-1:0] ci, di;   // C and D of task i
  logic [TB-1:0] prev;     // R of the last pass
  logic [TB-1:0] acc;      // R being built, never above di
  logic [TB-1:0] cj;
  logic [TB-1:0] k;        // ceil(prev / Tj)
  logic [2*TB-1:0] term;

  // single read port onto the table, new task on the extra code
  logic [IW-1:0] rd_idx;
  logic [SW-1:0] rd_s;
  logic          rd_new, rd_present;
  logic [TB-1:0] rd_c, rd_t, rd_d;
  logic          rd_hp;

  always_comb begin
    rd_idx = (state == S_NEXT_I) ? i : j;
    rd_new = (rd_idx == IW'(SLOTS));
    rd_s   = rd_idx[SW-1:0];
    if (rd_new) begin
      rd_present = 1'b1;
      rd_c       = req_q.wcet;
      rd_t       = req_q.period;
      rd_d       = req_q.deadline;
    end else begin
      rd_present = slot_valid[rd_s];
      rd_c       = slot_exec[rd_s];
      rd_t       = slot_period[rd_s];
      rd_d       = slot_deadline[rd_s];
    end
    if (rd_t == '0) rd_t = TB'(1);   // zero period acts as 1
    // higher priority: earlier deadline, ties by slot order, new task last
    rd_hp = (rd_d < di) || ((rd_d == di) && (rd_idx < i));
  end

  // deactivate match and free-slot search
  logic [SLOTS-1:0] match;
  logic [SW-1:0]    free_slot;
  logic             full;

  always_comb begin
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      match[s] = slot_valid[s] && (slot_task[s] == req_q.task_id);
      if (!slot_valid[s]) free_slot = SW'(s);
    end
    full = &slot_valid;
  end

  // shared divider
  logic          div_start, div_done, div_rem_nz;
  logic [TB-1:0] div_quo;

  rta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prev),
    .divisor  (rd_t),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  logic [TB-1:0] room;
  logic          acc_fail;
  assign room     = di - acc;
  assign acc_fail = (term > {{TB{1'b0}}, room});

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_IDLE:   if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (req_q.command == CMD_DEACTIVATE || full) state_next = S_RESP;
        else                                        state_next = S_NEXT_I;
      end
      S_NEXT_I: begin
        if (!rd_present || rd_c == '0) begin
          if (i == IW'(SLOTS)) state_next = S_ADMIT;
        end else if (rd_c > rd_d) begin
          state_next = S_REJECT;
        end else begin
          state_next = S_J_SCAN;
        end
      end
      S_J_SCAN: begin
        if (rd_present && rd_hp) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (j == IW'(SLOTS)) begin
          state_next = S_PASS_END;
        end
      end
      S_DIV:    if (div_done) state_next = S_MUL;
      S_MUL:    state_next = S_ACC;
      S_ACC: begin
        if (acc_fail)              state_next = S_REJECT;
        else if (j == IW'(SLOTS))  state_next = S_PASS_END;
        else                       state_next = S_J_SCAN;
      end
      S_PASS_END: begin
        if (acc != prev)           state_next = S_J_SCAN;
        else if (i == IW'(SLOTS))  state_next = S_ADMIT;
        else                       state_next = S_NEXT_I;
      end
      S_ADMIT:  state_next = S_RESP;
      S_REJECT: state_next = S_RESP;
      S_RESP:   if (rsp_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:   if (req_valid) req_q <= req;
      S_DECODE: begin
        rsp.slot          <= '0;
        rsp.removed_count <= '0;
        i                 <= '0;
        if (req_q.command == CMD_DEACTIVATE) begin
          rsp.status        <= STAT_DEACT;
          rsp.removed_count <= 4'($countones(match));
        end else begin
          rsp.status <= STAT_FULL;
        end
      end
      S_NEXT_I: begin
        if (!rd_present || rd_c == '0) begin
          if (i != IW'(SLOTS)) i <= i + 1'b1;
        end else begin
          ci   <= rd_c;
          di   <= rd_d;
          prev <= rd_c;
          acc  <= rd_c;
          j    <= '0;
        end
      end
      S_J_SCAN: begin
        if (rd_present && rd_hp) cj <= rd_c;
        else if (j != IW'(SLOTS)) j <= j + 1'b1;
      end
      S_DIV:  if (div_done) k <= div_quo + TB'(div_rem_nz);
      S_MUL:  term <= k * cj;
      S_ACC: begin
        acc <= acc + term[TB-1:0];
        if (j != IW'(SLOTS)) j <= j + 1'b1;
      end
      S_PASS_END: begin
        if (acc != prev) begin
          prev <= acc;
          acc  <= ci;
          j    <= '0;
        end else if (i != IW'(SLOTS)) begin
          i <= i + 1'b1;
        end
      end
      S_ADMIT: begin
        rsp.status               <= STAT_ADMIT;
        rsp.slot                 <= 4'(free_slot);
        slot_task[free_slot]     <= req_q.task_id;
        slot_exec[free_slot]     <= req_q.wcet;
        slot_period[free_slot]   <= req_q.period;
        slot_deadline[free_slot] <= req_q.deadline;
      end
      S_REJECT: rsp.status <= STAT_NOSCHED;
      default: ;
    endcase
  end

  // valid bits: the only table state that reset touches
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (state == S_DECODE && req_q.command == CMD_DEACTIVATE) begin
      slot_valid <= slot_valid & ~match;
    end else if (state == S_ADMIT) begin
      slot_valid[free_slot] <= 1'b1;
    end
  end

  assign req_ready = (state == S_IDLE) && !rst;
  assign rsp_valid = (state == S_RESP);

  // ---------------- assertions ----------------
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_J_SCAN) |-> (acc <= di))
    else $error("response accumulator passed the deadline");

  a_monotone: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS_END && acc != prev) |-> (acc > prev))
    else $error("response time iteration went backwards");

  a_admit_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADMIT) |=> (rsp.status == STAT_ADMIT && slot_valid[rsp.slot[SW-1:0]]))
    else $error("admitted slot not marked valid");

  a_div_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> (state == S_MUL))
    else $error("divider result not consumed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid)
    else $error("new request taken while a response is pending");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Admission-control regression: a directed request table followed by random
// task sets, each response checked against a typed answer or a response-time-analysis predictor.
// ----------------------------------------------------------------------------
module tb;
  import rta_pkg::*;

  localparam int           NUM_RAND   = 120;
  localparam longint       CYCLE_CAP  = 40_000_000;
  localparam logic [23:0]  TMAX       = 24'hFFFFFF;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  rta_admission_control u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the task table.
  bit              tbl_valid [SLOTS];
  logic [5:0]      tbl_id    [SLOTS];
  longint unsigned tbl_c     [SLOTS];
  longint unsigned tbl_t     [SLOTS];
  longint unsigned tbl_d     [SLOTS];

  rsp_t   verdict_q[$];
  int     errors  = 0;
  int     snd_pct = 0;
  int     rcv_pct = 0;
  longint cycles  = 0;

  // Fixed-point response-time test over a set already in priority order.
  function automatic bit deadlines_met(longint unsigned c[], longint unsigned t[],
                                       longint unsigned d[], int n);
    longint unsigned r, prev, tj, k, term;
    for (int i = 0; i < n; i++) begin
      r    = c[i];
      prev = 0;
      while (r != prev) begin
        prev = r;
        r    = c[i];
        if (r > d[i]) return 1'b0;
        for (int j = 0; j < i; j++) begin
          tj   = (t[j] == 0) ? 1 : t[j];
          k    = (prev + tj - 1) / tj;
          term = k * c[j];
          if (term > d[i] - r) return 1'b0;
          r += term;
        end
      end
    end
    return 1'b1;
  endfunction

  // Predicts the response to one request and updates the shadow table.
  function automatic rsp_t admit_predict(req_t x);
    rsp_t            v;
    longint unsigned oc[], ot[], od[];
    int              n, k, free_slot;
    oc = new[SLOTS + 1];
    ot = new[SLOTS + 1];
    od = new[SLOTS + 1];
    v  = '{status: STAT_ADMIT, slot: 4'd0, removed_count: 4'd0};
    n  = 0;
    free_slot = -1;
    if (x.command == CMD_DEACTIVATE) begin
      v.status = STAT_DEACT;
      for (int i = 0; i < SLOTS; i++)
        if (tbl_valid[i] && tbl_id[i] == x.task_id) begin
          tbl_valid[i] = 1'b0;
          v.removed_count++;
        end
      return v;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) begin
        if (free_slot < 0) free_slot = i;
        continue;
      end
      // stable insert: equal deadlines keep slot order
      k = n;
      while (k > 0 && od[k-1] > tbl_d[i]) begin
        oc[k] = oc[k-1]; ot[k] = ot[k-1]; od[k] = od[k-1];
        k--;
      end
      oc[k] = tbl_c[i]; ot[k] = tbl_t[i]; od[k] = tbl_d[i];
      n++;
    end
    if (free_slot < 0) begin
      v.status = STAT_FULL;
      return v;
    end
    // new task goes behind every task of equal deadline
    k = n;
    while (k > 0 && od[k-1] > x.deadline) begin
      oc[k] = oc[k-1]; ot[k] = ot[k-1]; od[k] = od[k-1];
      k--;
    end
    oc[k] = x.wcet; ot[k] = x.period; od[k] = x.deadline;
    n++;
    if (!deadlines_met(oc, ot, od, n)) begin
      v.status = STAT_NOSCHED;
      return v;
    end
    tbl_valid[free_slot] = 1'b1;
    tbl_id[free_slot]    = x.task_id;
    tbl_c[free_slot]     = x.wcet;
    tbl_t[free_slot]     = x.period;
    tbl_d[free_slot]     = x.deadline;
    v.slot = free_slot[3:0];
    return v;
  endfunction

  // Drives one request; returns once it has been taken.
  task automatic send_request(req_t x, bit has_want, rsp_t want);
    rsp_t p;
    if ($urandom_range(99) < snd_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= x;
    do @(posedge clk); while (!req_ready);
    p = admit_predict(x);
    verdict_q.push_back(has_want ? want : p);
  endtask

  // Mostly sane task sets so the iteration converges or fails quickly;
  // a few wide-valued requests and deactivates keep the table churning.
  function automatic req_t random_request();
    req_t x;
    int   pick, per;
    pick = $urandom_range(99);
    x.task_id = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(7));
    if (pick < 30) begin
      x.command   = CMD_DEACTIVATE;
      x.wcet      = 24'($urandom);
      x.period    = 24'($urandom);
      x.deadline  = 24'($urandom);
    end else if (pick < 94) begin
      per = $urandom_range(100, 400);
      x.command   = CMD_ACTIVATE;
      x.period    = 24'(per);
      x.wcet      = 24'($urandom_range(per / 6, per / 3));
      x.deadline  = 24'($urandom_range(per / 3, 2 * per));
    end else begin
      x.command   = CMD_ACTIVATE;
      x.wcet      = 24'($urandom);
      x.period    = 24'($urandom_range(1, TMAX));
      x.deadline  = 24'($urandom);
    end
    return x;
  endfunction

  typedef struct {
    req_t x;
    bit   has_want;
    rsp_t want;
  } stim_row_t;

  function automatic stim_row_t row(logic cmd, logic [5:0] id, logic [23:0] c,
                                    logic [23:0] t, logic [23:0] d, bit has_want,
                                    status_t st, logic [3:0] sl, logic [3:0] rc);
    stim_row_t s;
    s.x        = '{command: cmd, task_id: id, wcet: c, period: t, deadline: d};
    s.has_want = has_want;
    s.want     = '{status: st, slot: sl, removed_count: rc};
    return s;
  endfunction

  // Response checker; ready toggles at random per the current idle mode.
  always @(posedge clk) begin
    rsp_t exp_v;
    rsp_ready <= ($urandom_range(99) >= rcv_pct);
    if (!rst && rsp_valid && rsp_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected response st=%0d slot=%0d rm=%0d", $realtime,
                 rsp.status, rsp.slot, rsp.removed_count);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (rsp.status !== exp_v.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, exp_v.status, rsp.status);
          errors++;
        end
        if (rsp.slot !== exp_v.slot) begin
          $display("%0t: slot exp %0d got %0d", $realtime, exp_v.slot, rsp.slot);
          errors++;
        end
        if (rsp.removed_count !== exp_v.removed_count) begin
          $display("%0t: removed_count exp %0d got %0d", $realtime,
                   exp_v.removed_count, rsp.removed_count);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("rta_admission_control regression: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t dir[$];
    stim_row_t s;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;

    // directed requests; typed answers only where obvious
    dir.push_back(row(CMD_DEACTIVATE, 6'd5, 0, 0, 0, 1, STAT_DEACT, 0, 0));
    dir.push_back(row(CMD_ACTIVATE, 6'd1, TMAX, TMAX, TMAX, 1, STAT_ADMIT, 0, 0));
    // zero deadline ahead of everything, C=1 misses
    dir.push_back(row(CMD_ACTIVATE, 6'd2, 1, 1, 0, 1, STAT_NOSCHED, 0, 0));
    dir.push_back(row(CMD_DEACTIVATE, 6'd1, 0, 0, 0, 1, STAT_DEACT, 0, 1));
    // zero execution time and zero period
    dir.push_back(row(CMD_ACTIVATE, 6'd3, 0, 0, 0, 1, STAT_ADMIT, 0, 0));
    dir.push_back(row(CMD_ACTIVATE, 6'd3, 10, 100, 50, 0, STAT_ADMIT, 0, 0));
    for (int i = 0; i < 8; i++)
      dir.push_back(row(CMD_ACTIVATE, 6'd4, 5, 200, 200, 0, STAT_ADMIT, 0, 0));
    dir.push_back(row(CMD_ACTIVATE, 6'd9, 1, 10, 10, 1, STAT_FULL, 0, 0));
    dir.push_back(row(CMD_DEACTIVATE, 6'd4, 0, 0, 0, 1, STAT_DEACT, 0, 8));
    dir.push_back(row(CMD_ACTIVATE, 6'd63, 24'h800000, TMAX, 24'h7FFFFF,
                      0, STAT_ADMIT, 0, 0));
    dir.push_back(row(CMD_DEACTIVATE, 6'd3, 0, 0, 0, 1, STAT_DEACT, 0, 2));
    dir.push_back(row(CMD_ACTIVATE, 6'h2A, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                      1, STAT_ADMIT, 0, 0));
    dir.push_back(row(CMD_ACTIVATE, 6'h15, 24'h555555, 24'hAAAAAA, 24'h555555,
                      0, STAT_ADMIT, 0, 0));
    dir.push_back(row(CMD_DEACTIVATE, 6'h2A, 0, 0, 0, 1, STAT_DEACT, 0, 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_pct = 35;
    rcv_pct = 47;
    foreach (dir[i]) begin
      s = dir[i];
      send_request(s.x, s.has_want, s.want);
    end

    // hold off until the table is quiet before the random phase
    req_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);

    for (int n = 0; n < NUM_RAND; n++) begin
      if (n == NUM_RAND / 3) begin
        snd_pct = 47;
        rcv_pct = 35;
      end else if (n == 2 * NUM_RAND / 3) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      send_request(random_request(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("rta_admission_control regression: pass");
    end else begin
      $display("rta_admission_control regression: fail");
    end
    $finish;
  end

endmodule
